>>> rtl/core/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the periodic task table
// Field widths, status and op codes, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ptt_pkg;

	// default table depth
	localparam int ENTRIES_DEF = 16;

	// field widths
	localparam int OP_W     = 2;
	localparam int KEY_W    = 32;
	localparam int PHASE_W  = 16;
	localparam int PERIOD_W = 16;
	localparam int TICK_W   = 32;
	localparam int SLOT_W   = 4;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;
	localparam int WM_W     = 5;

	// request bus layout, lowest bit first
	localparam int KEY_LO    = 0;
	localparam int PHASE_LO  = KEY_LO + KEY_W;
	localparam int PERIOD_LO = PHASE_LO + PHASE_W;
	localparam int REPL_LO   = PERIOD_LO + PERIOD_W;
	localparam int TICK_LO   = REPL_LO + 1;
	localparam int SLOT_LO   = TICK_LO + TICK_W;
	localparam int IN_BITS   = SLOT_LO + SLOT_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

	// result bus layout, lowest bit first
	localparam int ST_LO      = 0;
	localparam int CNT_LO     = ST_LO + STATUS_W;
	localparam int HIT_LO     = CNT_LO + COUNT_W;
	localparam int DUE_LO     = HIT_LO + 1;
	localparam int OUT_BITS   = DUE_LO + 1;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_DEL   = 2'd1,
		OP_QUERY = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_EXISTS    = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0]    key;
		logic [PHASE_W-1:0]  phase;
		logic [PERIOD_W-1:0] period;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_APPEND,
		S_REPLACE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_CLEAR,
		S_QRY_RD,
		S_QRY_DIV,
		S_QRY_WAIT,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		RD_IDX,
		RD_NEXT,
		RD_SLOT
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NEW,
		WR_SHIFT,
		WR_CLEAR
	} wr_sel_t;

	typedef enum logic [1:0] {
		DUE_ZERO,
		DUE_ONE,
		DUE_CMP
	} due_sel_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     idx_inc;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     wr_en;
		wr_sel_t  wr_sel;
		logic     cnt_inc;
		logic     cnt_dec;
		logic     rem_start;
		logic     pend_set;
		status_t  pend_status;
		due_sel_t due_sel;
		logic     hit_chk;
		logic     out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic replace;
		logic full;
		logic empty;
		logic match;
		logic last;
		logic near_end;
		logic slot_oob;
		logic slot_unused;
		logic rem_busy;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/core/periodic_task_table.sv
// Sequence, from request to result: add or delete search the entries by key, and a delete
//   shifts every entry behind the match down one slot; a due query of an occupied slot runs
//   the 32-step serial remainder unit. Full, empty, an unused slot and op 3 need neither.
// Throughput: one request at a time; the next request is taken while a result still waits.
// Reset: arst_n clears the controller, entry count and result valid at once and sets the
//   watermark level to ENTRIES; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
// periodic_task_table: compact table of periodic tasks
// Add, rewrite and delete with compaction over a key-searched entry memory,
// plus a due query per slot. Controller and datapath are separate modules.
// ----------------------------------------------------------------------------
module periodic_task_table #(
	parameter int ENTRIES = ptt_pkg::ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// tdata: task_key[31:0], phase[47:32], period[63:48], replace[64],
	//        tick_now[96:65], slot[100:97], zero fill to 104 bits
	input  logic [ptt_pkg::IN_DATA_W-1:0]  s_tdata,
	// tuser: op[1:0]
	input  logic [ptt_pkg::OP_W-1:0]       s_tuser,
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// tdata: status[2:0], count[7:3], watermark_hit[8], due[9], zero fill to 16 bits
	output logic [ptt_pkg::OUT_DATA_W-1:0] m_tdata,
	// watermark level register
	input  logic                           cfg_we,
	input  logic [ptt_pkg::WM_W-1:0]       cfg_wdata
);
	import ptt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing
	ptt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// storage and arithmetic
	ptt_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req_op    (s_tuser),
		.req_data  (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res_data  (m_tdata)
	);

endmodule

>>> rtl/core/ptt_rem.sv
// ----------------------------------------------------------------------------
// ptt_rem: serial remainder unit
// Restoring division of the tick by the period, one quotient bit per cycle;
// only the remainder is kept.
// ----------------------------------------------------------------------------
module ptt_rem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ptt_pkg::TICK_W-1:0]   dividend,
	input  logic [ptt_pkg::PERIOD_W-1:0] divisor,
	output logic                         busy,
	output logic [ptt_pkg::PERIOD_W-1:0] rem
);
	import ptt_pkg::*;

	localparam int STEPS  = TICK_W;
	localparam int STEP_W = $clog2(STEPS + 1);

	logic [TICK_W-1:0]   dvd_q;
	logic [PERIOD_W-1:0] rem_q;
	logic [PERIOD_W-1:0] dsr_q;
	logic [STEP_W-1:0]   step_q;
	logic                busy_q;
	logic [PERIOD_W:0]   trial;

	// shift in the next dividend bit
	assign trial = {rem_q, dvd_q[TICK_W-1]};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(STEPS);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			busy_q <= (step_q != STEP_W'(1));
		end
	end

	// subtract when the trial remainder reaches the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[TICK_W-2:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= PERIOD_W'(trial - {1'b0, dsr_q});
			end else begin
				rem_q <= trial[PERIOD_W-1:0];
			end
		end
	end

	assign busy = busy_q;
	assign rem  = rem_q;

endmodule

>>> rtl/core/ptt_dpath.sv
// ----------------------------------------------------------------------------
// ptt_dpath: table datapath
// Request registers, entry memory, search and shift pointer, entry count,
// watermark register, remainder unit and result register.
// ----------------------------------------------------------------------------
module ptt_dpath #(
	parameter int ENTRIES = ptt_pkg::ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ptt_pkg::cmd_t                  cmd,
	output ptt_pkg::sts_t                  sts,
	input  logic [ptt_pkg::OP_W-1:0]       req_op,
	input  logic [ptt_pkg::IN_DATA_W-1:0]  req_data,
	input  logic                           cfg_we,
	input  logic [ptt_pkg::WM_W-1:0]       cfg_wdata,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [ptt_pkg::OUT_DATA_W-1:0] res_data
);
	import ptt_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	// request fields
	op_t                 op_q;
	logic [KEY_W-1:0]    key_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [PERIOD_W-1:0] period_q;
	logic                repl_q;
	logic [TICK_W-1:0]   tick_q;
	logic [SLOT_W-1:0]   slot_q;

	// control registers
	logic [CW-1:0]   cnt_q;
	logic [CW-1:0]   idx_q;
	logic [WM_W-1:0] wm_q;
	logic            out_valid_q;

	// pending and delivered result
	status_t             pend_status_q;
	logic                pend_hit_q;
	logic                pend_due_q;
	logic [OUT_BITS-1:0] out_q;

	// entry memory
	entry_t        mem [ENTRIES];
	entry_t        rd_q;
	entry_t        wr_data;
	logic [AW-1:0] rd_addr;
	logic [CW-1:0] idx_nxt;

	// remainder unit
	logic [PERIOD_W-1:0] divisor;
	logic [PERIOD_W-1:0] rem;
	logic                rem_busy;
	logic                due_val;

	// capture the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(req_op);
			key_q    <= req_data[KEY_LO +: KEY_W];
			phase_q  <= req_data[PHASE_LO +: PHASE_W];
			period_q <= req_data[PERIOD_LO +: PERIOD_W];
			repl_q   <= req_data[REPL_LO];
			tick_q   <= req_data[TICK_LO +: TICK_W];
			slot_q   <= req_data[SLOT_LO +: SLOT_W];
		end
	end

	// pointer, count, watermark and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cnt_q       <= '0;
			wm_q        <= WM_W'(ENTRIES);
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_nxt;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cfg_we) begin
				wm_q <= cfg_wdata;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign idx_nxt = idx_q + CW'(1);

	// select read address and write data
	always_comb begin
		case (cmd.rd_sel)
			RD_IDX:  rd_addr = idx_q[AW-1:0];
			RD_NEXT: rd_addr = idx_nxt[AW-1:0];
			RD_SLOT: rd_addr = AW'(slot_q);
			default: rd_addr = idx_q[AW-1:0];
		endcase
		case (cmd.wr_sel)
			WR_NEW:   wr_data = '{key: key_q, phase: phase_q, period: period_q};
			WR_SHIFT: wr_data = rd_q;
			WR_CLEAR: wr_data = '{key: '0, phase: '0, period: PERIOD_W'(1)};
			default:  wr_data = rd_q;
		endcase
	end

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[idx_q[AW-1:0]] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// tick modulo max(period, 1)
	assign divisor = (rd_q.period == '0) ? PERIOD_W'(1) : rd_q.period;

	ptt_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.rem_start),
		.dividend (tick_q),
		.divisor  (divisor),
		.busy     (rem_busy),
		.rem      (rem)
	);

	always_comb begin
		case (cmd.due_sel)
			DUE_ZERO: due_val = 1'b0;
			DUE_ONE:  due_val = 1'b1;
			DUE_CMP:  due_val = (rd_q.phase == rem);
			default:  due_val = 1'b0;
		endcase
	end

	// hold the result until the output register is free
	always_ff @(posedge clk) begin
		if (cmd.pend_set) begin
			pend_status_q <= cmd.pend_status;
			pend_due_q    <= due_val;
			pend_hit_q    <= cmd.hit_chk && ((32'(cnt_q) + 1) == 32'(wm_q));
		end
		if (cmd.out_load) begin
			out_q <= {pend_due_q, pend_hit_q, COUNT_W'(cnt_q), pend_status_q};
		end
	end

	assign res_valid = out_valid_q;
	assign res_data  = OUT_DATA_W'(out_q);

	// status toward the controller
	always_comb begin
		sts.op          = op_q;
		sts.replace     = repl_q;
		sts.full        = (32'(cnt_q) >= 32'(ENTRIES));
		sts.empty       = (cnt_q == '0);
		sts.match       = (rd_q.key == key_q);
		sts.last        = ((32'(idx_q) + 1) >= 32'(cnt_q));
		sts.near_end    = ((32'(idx_q) + 2) >= 32'(cnt_q));
		sts.slot_oob    = (32'(slot_q) >= 32'(ENTRIES));
		sts.slot_unused = (32'(slot_q) >= 32'(cnt_q));
		sts.rem_busy    = rem_busy;
		sts.out_free    = !out_valid_q || res_ready;
	end

endmodule

>>> rtl/core/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// ptt_ctrl: table controller
// Sequences the key search, the append or rewrite, the compaction shift and
// the due query, then hands the result to the output register.
// ----------------------------------------------------------------------------
module ptt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ptt_pkg::sts_t sts,
	output ptt_pkg::cmd_t cmd
);
	import ptt_pkg::*;

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.op)
					OP_ADD: begin
						if (sts.full) begin
							cmd.pend_set    = 1'b1;
							cmd.pend_status = ST_FULL;
							state_d         = S_FINISH;
						end else if (sts.empty) begin
							state_d = S_APPEND;
						end else begin
							state_d = S_SRCH_RD;
						end
					end
					OP_DEL: begin
						if (sts.empty) begin
							cmd.pend_set    = 1'b1;
							cmd.pend_status = ST_EMPTY;
							state_d         = S_FINISH;
						end else begin
							state_d = S_SRCH_RD;
						end
					end
					OP_QUERY: begin
						if (sts.slot_oob) begin
							cmd.pend_set    = 1'b1;
							cmd.pend_status = ST_NOT_FOUND;
							state_d         = S_FINISH;
						end else if (sts.slot_unused) begin
							// unused slots are answered as phase 0, period 1: always due
							cmd.pend_set    = 1'b1;
							cmd.pend_status = ST_OK;
							cmd.due_sel     = DUE_ONE;
							state_d         = S_FINISH;
						end else begin
							state_d = S_QRY_RD;
						end
					end
					default: begin
						cmd.pend_set    = 1'b1;
						cmd.pend_status = ST_OK;
						state_d         = S_FINISH;
					end
				endcase
			end
			// search: read the entry under the pointer, compare next cycle
			S_SRCH_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_IDX;
				state_d    = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (sts.match) begin
					if (sts.op == OP_DEL) begin
						state_d = sts.last ? S_CLEAR : S_SHIFT_RD;
					end else if (sts.replace) begin
						state_d = S_REPLACE;
					end else begin
						cmd.pend_set    = 1'b1;
						cmd.pend_status = ST_EXISTS;
						state_d         = S_FINISH;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					if (!sts.last) begin
						state_d = S_SRCH_RD;
					end else if (sts.op == OP_DEL) begin
						cmd.pend_set    = 1'b1;
						cmd.pend_status = ST_NOT_FOUND;
						state_d         = S_FINISH;
					end else begin
						state_d = S_APPEND;
					end
				end
			end
			S_APPEND: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_sel      = WR_NEW;
				cmd.cnt_inc     = 1'b1;
				cmd.pend_set    = 1'b1;
				cmd.pend_status = ST_OK;
				cmd.hit_chk     = 1'b1;
				state_d         = S_FINISH;
			end
			S_REPLACE: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_sel      = WR_NEW;
				cmd.pend_set    = 1'b1;
				cmd.pend_status = ST_OK;
				state_d         = S_FINISH;
			end
			// compaction: move the following entry down one slot
			S_SHIFT_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_NEXT;
				state_d    = S_SHIFT_WR;
			end
			S_SHIFT_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_sel  = WR_SHIFT;
				cmd.idx_inc = 1'b1;
				state_d     = sts.near_end ? S_CLEAR : S_SHIFT_RD;
			end
			S_CLEAR: begin
				cmd.wr_en       = 1'b1;
				cmd.wr_sel      = WR_CLEAR;
				cmd.cnt_dec     = 1'b1;
				cmd.pend_set    = 1'b1;
				cmd.pend_status = ST_OK;
				state_d         = S_FINISH;
			end
			// due query: fetch the slot, then tick modulo period
			S_QRY_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RD_SLOT;
				state_d    = S_QRY_DIV;
			end
			S_QRY_DIV: begin
				cmd.rem_start = 1'b1;
				state_d       = S_QRY_WAIT;
			end
			S_QRY_WAIT: begin
				if (!sts.rem_busy) begin
					cmd.pend_set    = 1'b1;
					cmd.pend_status = ST_OK;
					cmd.due_sel     = DUE_CMP;
					state_d         = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

>>> test/tb_periodic_task_table.sv
// ----------------------------------------------------------------------------
// tb_periodic_task_table: self-checking bench for the periodic task table
// Requests go in through the request stream from a queue of pending work and
// results are checked in order against a table mirror kept in the bench. The
// watermark level changes between phases while the table is quiet. Both sides
// insert random gaps, with stretches of back-to-back traffic in between.
// ----------------------------------------------------------------------------
module tb_periodic_task_table;
	timeunit 1ns;
	timeprecision 1ps;

	import ptt_pkg::*;

	localparam int TABLE_DEPTH = ENTRIES_DEF;
	localparam int POOL_SIZE   = 20;

	typedef struct {
		op_t                 op;
		logic [KEY_W-1:0]    key;
		logic [PHASE_W-1:0]  phase;
		logic [PERIOD_W-1:0] period;
		logic                replace;
		logic [TICK_W-1:0]   tick;
		logic [SLOT_W-1:0]   slot;
	} task_req_t;

	typedef struct {
		status_t            status;
		logic [COUNT_W-1:0] count;
		logic               hit;
		logic               due;
	} table_result_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic [OP_W-1:0]       s_tuser   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [WM_W-1:0]       cfg_wdata = '0;

	periodic_task_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// table mirror
	logic [KEY_W-1:0]    mirror_key    [TABLE_DEPTH];
	logic [PHASE_W-1:0]  mirror_phase  [TABLE_DEPTH];
	logic [PERIOD_W-1:0] mirror_period [TABLE_DEPTH];
	int                  mirror_count = 0;
	int                  wm_level     = TABLE_DEPTH;

	task_req_t     pending_reqs[$];
	table_result_t expected_results[$];
	task_req_t     cur_req;
	bit            req_done  = 0;
	bit            no_idle   = 0;
	int            gap_left  = 0;
	int            stall_left = 0;
	int            err_cnt   = 0;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// mostly short gaps, a few long ones, none during a back-to-back stretch
	function automatic int draw_gap();
		int r;
		r = $urandom_range(99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic int find_entry(logic [KEY_W-1:0] key);
		int k;
		for (k = 0; k < mirror_count; k++)
			if (mirror_key[k] == key)
				break;
		return k;
	endfunction

	// apply one request to the mirror and return the result it must produce
	function automatic table_result_t apply_table_op(task_req_t r);
		table_result_t res;
		int k;
		logic [TICK_W-1:0] per;
		res.status = ST_OK;
		res.hit    = 1'b0;
		res.due    = 1'b0;
		case (r.op)
			OP_ADD: begin
				if (mirror_count >= TABLE_DEPTH) begin
					res.status = ST_FULL;
				end else begin
					k = find_entry(r.key);
					if (k < mirror_count && !r.replace) begin
						res.status = ST_EXISTS;
					end else begin
						mirror_key[k]    = r.key;
						mirror_phase[k]  = r.phase;
						mirror_period[k] = r.period;
						if (k >= mirror_count) begin
							mirror_count++;
							res.hit = (mirror_count == wm_level);
						end
					end
				end
			end
			OP_DEL: begin
				if (mirror_count == 0) begin
					res.status = ST_EMPTY;
				end else begin
					k = find_entry(r.key);
					if (k >= mirror_count) begin
						res.status = ST_NOT_FOUND;
					end else begin
						// close the gap, then reset the vacated slot
						for (; k + 1 < mirror_count; k++) begin
							mirror_key[k]    = mirror_key[k + 1];
							mirror_phase[k]  = mirror_phase[k + 1];
							mirror_period[k] = mirror_period[k + 1];
						end
						mirror_key[k]    = '0;
						mirror_phase[k]  = '0;
						mirror_period[k] = 16'd1;
						mirror_count--;
					end
				end
			end
			OP_QUERY: begin
				// a stored period of zero counts as one
				per = (mirror_period[r.slot] == 0) ? 32'd1 : 32'(mirror_period[r.slot]);
				res.due = (32'(mirror_phase[r.slot]) == r.tick % per);
			end
			default: ;
		endcase
		res.count = COUNT_W'(mirror_count);
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		err_cnt++;
		$display("ERROR at %0t ns: %s", $realtime, msg);
	endtask

	task automatic push_req(input op_t op, input logic [KEY_W-1:0] key,
			input logic [PHASE_W-1:0] phase, input logic [PERIOD_W-1:0] period,
			input logic replace, input logic [TICK_W-1:0] tick,
			input logic [SLOT_W-1:0] slot);
		task_req_t r;
		r.op      = op;
		r.key     = key;
		r.phase   = phase;
		r.period  = period;
		r.replace = replace;
		r.tick    = tick;
		r.slot    = slot;
		pending_reqs.push_back(r);
	endtask

	// random request: keys mostly from a small pool so searches hit
	task automatic push_random_req(input bit filling);
		op_t op;
		int r;
		logic [KEY_W-1:0] key;
		logic [PERIOD_W-1:0] period;
		logic [PHASE_W-1:0] phase;
		logic [TICK_W-1:0] tick;
		r = $urandom_range(99);
		if (r < (filling ? 65 : 20))
			op = OP_ADD;
		else if (r < 80)
			op = OP_DEL;
		else if (r < 97)
			op = OP_QUERY;
		else
			op = OP_NOP;
		key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
		r = $urandom_range(9);
		if (r < 3)
			period = PERIOD_W'($urandom_range(4));
		else if (r < 7)
			period = PERIOD_W'($urandom_range(40));
		else
			period = PERIOD_W'($urandom);
		if ($urandom_range(1) && period != 0)
			phase = PHASE_W'($urandom_range(int'(period) - 1));
		else
			phase = PHASE_W'($urandom);
		tick = $urandom_range(1) ? TICK_W'($urandom_range(200)) : TICK_W'($urandom);
		push_req(op, key, phase, period, 1'($urandom_range(1)), tick,
			SLOT_W'($urandom_range(TABLE_DEPTH - 1)));
	endtask

	// hold until no request is pending, in flight or awaiting its result
	task automatic wait_quiet();
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0);
	endtask

	task automatic write_watermark(input int level);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= WM_W'(level);
		wm_level  = level;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// record each accepted request in the mirror
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			expected_results.push_back(apply_table_op(cur_req));
			req_done = 1;
		end
	end

	// drive the request stream from the pending queue
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_done) begin
			req_done = 0;
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() != 0) begin
				cur_req = pending_reqs.pop_front();
				s_tdata <= IN_DATA_W'({cur_req.slot, cur_req.tick, cur_req.replace,
					cur_req.period, cur_req.phase, cur_req.key});
				s_tuser  <= cur_req.op;
				s_tvalid <= 1'b1;
				gap_left = draw_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// stall the result stream at random
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			stall_left = draw_gap();
		end
	end

	// check each result against the oldest expectation
	always @(posedge clk) begin
		table_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("result 0x%h with nothing expected", m_tdata));
			end else begin
				want = expected_results.pop_front();
				if (m_tdata[ST_LO +: STATUS_W] !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						m_tdata[ST_LO +: STATUS_W], want.status));
				if (m_tdata[CNT_LO +: COUNT_W] !== want.count)
					report_mismatch($sformatf("count %0d, expected %0d",
						m_tdata[CNT_LO +: COUNT_W], want.count));
				if (m_tdata[HIT_LO] !== want.hit)
					report_mismatch($sformatf("watermark_hit %b, expected %b",
						m_tdata[HIT_LO], want.hit));
				if (m_tdata[DUE_LO] !== want.due)
					report_mismatch($sformatf("due %b, expected %b",
						m_tdata[DUE_LO], want.due));
			end
		end
	end

	initial begin
		int levels [6];
		bit filling;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			mirror_key[k]    = '0;
			mirror_phase[k]  = '0;
			mirror_period[k] = 16'd1;
		end
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int k = 2; k < POOL_SIZE; k++)
			key_pool[k] = $urandom;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table: query reset contents, delete, idle op
		push_req(OP_QUERY, '0, '0, '0, 1'b0, 32'd0, 4'd0);
		push_req(OP_DEL, 32'd5, '0, '0, 1'b0, '0, '0);
		push_req(OP_NOP, '1, '1, '1, 1'b1, '1, '1);
		// extreme keys, zero period, new key with replace set
		push_req(OP_ADD, '0, '0, '0, 1'b0, '0, '0);
		push_req(OP_ADD, '1, '1, '1, 1'b1, '0, '0);
		// existing key refused, then rewritten
		push_req(OP_ADD, '0, 16'd3, 16'd7, 1'b0, '0, '0);
		push_req(OP_ADD, '0, 16'd3, 16'd7, 1'b1, '0, '0);
		push_req(OP_QUERY, '0, '0, '0, 1'b0, 32'd10, 4'd0);
		push_req(OP_QUERY, '0, '0, '0, 1'b0, '1, 4'd1);
		// slot past the count answers from reset values
		push_req(OP_QUERY, '0, '0, '0, 1'b0, 32'd7, 4'd15);
		push_req(OP_DEL, 32'h12345, '0, '0, 1'b0, '0, '0);
		// fill up to the watermark, then try one more
		for (int i = 0; i < TABLE_DEPTH - 2; i++)
			push_req(OP_ADD, 32'h100 + i, PHASE_W'(i), PERIOD_W'(i + 1), 1'b0, '0, '0);
		push_req(OP_ADD, 32'd999, '0, '0, 1'b0, '0, '0);
		// delete first and last, then query the vacated slot
		push_req(OP_DEL, '0, '0, '0, 1'b0, '0, '0);
		push_req(OP_DEL, 32'h100 + TABLE_DEPTH - 3, '0, '0, 1'b0, '0, '0);
		push_req(OP_QUERY, '0, '0, '0, 1'b0, 32'd0, 4'd15);
		wait_quiet();

		// random phases, each under its own watermark level
		levels = '{0, 1, TABLE_DEPTH, TABLE_DEPTH - 1, $urandom_range(14, 2), 8};
		filling = 1;
		for (int p = 0; p < 6; p++) begin
			write_watermark(levels[p]);
			for (int i = 0; i < 200; i++) begin
				if (i % 40 == 0) begin
					filling = ~filling;
					no_idle = ($urandom_range(3) == 0);
				end
				push_random_req(filling);
			end
			wait_quiet();
		end

		repeat (100) @(posedge clk);
		if (err_cnt == 0)
			$display("periodic_task_table: match");
		else
			$display("periodic_task_table: mismatch");
		$finish;
	end

	// give up on a hung run
	initial begin
		#8_000_000;
		$display("periodic_task_table: mismatch");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/ptt_pkg.sv
rtl/core/ptt_rem.sv
rtl/core/ptt_dpath.sv
rtl/core/ptt_ctrl.sv
rtl/core/periodic_task_table.sv
test/tb_periodic_task_table.sv
